/* hw/rtl/stt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int ELEM_W = 16;  // element value width on the stream
  localparam int DIM_W  = 4;   // row / column index and size width
  localparam int CNT_W  = 5;   // stored nonzero count width
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam int DEF_MAX_DIM     = 8;
  localparam int DEF_MAX_NONZERO = 16;
  localparam int DEF_VALUE_WIDTH = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // list kinds
  localparam logic KIND_TRIPLE    = 1'b0;
  localparam logic KIND_TRANSPOSE = 1'b1;

  // output beat layout
  localparam int RES_DATA_W = 2 * DIM_W + ELEM_W + 1;
  localparam int TDATA_W    = ((RES_DATA_W + 7) / 8) * 8;
  localparam int TDATA_PAD  = TDATA_W - RES_DATA_W;
  localparam int TUSER_W    = 2;

  typedef struct packed {
    logic [ELEM_W-1:0] val;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
  } trip_t;

  localparam int TRIP_W = $bits(trip_t);

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             ovf;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } job_t;

  typedef struct packed {
    logic              kind;
    logic              hdr;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [ELEM_W-1:0] val;
    logic              ovf;
    logic              last;
  } res_t;

  // size register as used: zero acts as one, clamp at the maximum
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] d, int max_dim);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (int'(d) > max_dim) begin
      r = DIM_W'(max_dim);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/stt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module stt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stt_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

// two-entry job queue between front and back
module stt_fifo import stt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output job_t      pop_data_o
);

  job_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stt_front.sv */
`timescale 1ns / 1ps
`default_nettype none

// Takes elements, tracks row/column, writes nonzero triples, posts a job at end of matrix.
module stt_front import stt_pkg::*; #(
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int MAX_NONZERO = DEF_MAX_NONZERO,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int ADDR_W      = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ELEM_W-1:0]     in_value_i,
  output logic                       ram_we_o,
  output logic      [ADDR_W-1:0]     ram_waddr_o,
  output trip_t                      ram_wdata_o,
  output logic                       job_push_o,
  output job_t                       job_o,
  input  wire logic                  job_full_i,
  input  wire logic                  job_done_i
);

  localparam int EffW  = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;
  localparam int ShAmt = ELEM_W - EffW;

  logic [DIM_W-1:0] row_cnt_q, col_cnt_q;
  logic [DIM_W-1:0] r_q, c_q;
  logic [CNT_W-1:0] nz_q, nz_d;
  logic             ovf_q, ovf_d;
  logic             lock_q;

  logic [DIM_W-1:0]         rows, cols;
  logic signed [ELEM_W-1:0] val_sh, val;
  logic                     accept, nonzero, store_ok, is_end;

  assign rows = eff_dim(row_cnt_q, MAX_DIM);
  assign cols = eff_dim(col_cnt_q, MAX_DIM);

  assign in_ready_o = !lock_q && !job_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // keep the low bits and sign-extend them
  assign val_sh  = $signed(in_value_i) <<< ShAmt;
  assign val     = val_sh >>> ShAmt;
  assign nonzero = (val != '0);

  assign store_ok = (nz_q < CNT_W'(MAX_NONZERO));
  assign is_end   = (r_q == rows - DIM_W'(1)) && (c_q == cols - DIM_W'(1));

  assign ram_we_o    = accept && nonzero && store_ok;
  assign ram_waddr_o = nz_q[ADDR_W-1:0];
  assign ram_wdata_o = '{val: val, col: c_q, row: r_q};

  assign nz_d  = nz_q + CNT_W'(ram_we_o);
  assign ovf_d = ovf_q | (accept && nonzero && !store_ok);

  assign job_push_o = accept && is_end;
  assign job_o      = '{n: nz_d, ovf: ovf_d, rows: rows, cols: cols};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= DIM_W'(1);
      col_cnt_q <= DIM_W'(1);
      r_q       <= '0;
      c_q       <= '0;
      nz_q      <= '0;
      ovf_q     <= 1'b0;
      lock_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ROW_COUNT:    row_cnt_q <= cfg_data_i;
          REG_COLUMN_COUNT: col_cnt_q <= cfg_data_i;
          default: ;
        endcase
        r_q   <= '0;
        c_q   <= '0;
        nz_q  <= '0;
        ovf_q <= 1'b0;
      end else if (accept) begin
        if (is_end) begin
          r_q   <= '0;
          c_q   <= '0;
          nz_q  <= '0;
          ovf_q <= 1'b0;
        end else begin
          nz_q  <= nz_d;
          ovf_q <= ovf_d;
          if (c_q == cols - DIM_W'(1)) begin
            c_q <= '0;
            r_q <= r_q + DIM_W'(1);
          end else begin
            c_q <= c_q + DIM_W'(1);
          end
        end
      end
      // store belongs to the back part until it has read every triple
      if (job_push_o) begin
        lock_q <= 1'b1;
      end else if (job_done_i) begin
        lock_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stt_back.sv */
`timescale 1ns / 1ps
`default_nettype none

// Emits the triple list, then scans the store once per column for the transpose.
module stt_back import stt_pkg::*; #(
  parameter int MAX_NONZERO = DEF_MAX_NONZERO,
  parameter int ADDR_W      = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  wire job_t             job_i,
  output logic                  job_pop_o,
  output logic                  job_done_o,
  output logic                  ram_re_o,
  output logic     [ADDR_W-1:0] ram_raddr_o,
  input  wire trip_t            ram_rdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output res_t                  out_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_A   = 3'd1;
  localparam logic [2:0] S_WAIT_A = 3'd2;
  localparam logic [2:0] S_HDR1   = 3'd3;
  localparam logic [2:0] S_RD_B   = 3'd4;
  localparam logic [2:0] S_WAIT_B = 3'd5;

  logic [2:0]       st_q, st_d;
  job_t             job_q, job_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] em_q, em_d;
  logic [DIM_W-1:0] col_q, col_d;
  logic             ov_q, ov_d;
  res_t             res_q, res_d;
  logic             ld, out_free, match, idx_end;

  assign out_free    = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_o       = res_q;
  assign ram_raddr_o = idx_q[ADDR_W-1:0];
  assign match       = (ram_rdata_i.col == col_q);
  assign idx_end     = (idx_q + CNT_W'(1) == job_q.n);

  always_comb begin
    st_d       = st_q;
    job_d      = job_q;
    idx_d      = idx_q;
    em_d       = em_q;
    col_d      = col_q;
    res_d      = res_q;
    ld         = 1'b0;
    job_pop_o  = 1'b0;
    job_done_o = 1'b0;
    ram_re_o   = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (job_valid_i && out_free) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          ld        = 1'b1;
          res_d     = '{kind: KIND_TRIPLE, hdr: 1'b1, row: job_i.rows, col: job_i.cols,
                        val: ELEM_W'(job_i.n), ovf: job_i.ovf, last: 1'b0};
          idx_d     = '0;
          st_d      = (job_i.n != '0) ? S_RD_A : S_HDR1;
        end
      end
      S_RD_A: begin
        ram_re_o = 1'b1;
        st_d     = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (out_free) begin
          ld    = 1'b1;
          res_d = '{kind: KIND_TRIPLE, hdr: 1'b0, row: ram_rdata_i.row,
                    col: ram_rdata_i.col, val: ram_rdata_i.val, ovf: job_q.ovf,
                    last: 1'b0};
          if (idx_end) begin
            st_d = S_HDR1;
          end else begin
            idx_d = idx_q + CNT_W'(1);
            st_d  = S_RD_A;
          end
        end
      end
      S_HDR1: begin
        if (out_free) begin
          ld    = 1'b1;
          res_d = '{kind: KIND_TRANSPOSE, hdr: 1'b1, row: job_q.cols, col: job_q.rows,
                    val: ELEM_W'(job_q.n), ovf: job_q.ovf, last: (job_q.n == '0)};
          idx_d = '0;
          em_d  = '0;
          col_d = '0;
          if (job_q.n == '0) begin
            job_done_o = 1'b1;
            st_d       = S_IDLE;
          end else begin
            st_d = S_RD_B;
          end
        end
      end
      S_RD_B: begin
        ram_re_o = 1'b1;
        st_d     = S_WAIT_B;
      end
      S_WAIT_B: begin
        if (!(match && !out_free)) begin
          if (match) begin
            ld    = 1'b1;
            em_d  = em_q + CNT_W'(1);
            res_d = '{kind: KIND_TRANSPOSE, hdr: 1'b0, row: ram_rdata_i.col,
                      col: ram_rdata_i.row, val: ram_rdata_i.val, ovf: job_q.ovf,
                      last: (em_q + CNT_W'(1) == job_q.n)};
          end
          if ((match && em_q + CNT_W'(1) == job_q.n) ||
              (idx_end && col_q == job_q.cols - DIM_W'(1))) begin
            job_done_o = 1'b1;
            st_d       = S_IDLE;
          end else begin
            st_d = S_RD_B;
            if (idx_end) begin
              idx_d = '0;
              col_d = col_q + DIM_W'(1);
            end else begin
              idx_d = idx_q + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ld) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    idx_q <= idx_d;
    em_q  <= em_d;
    col_q <= col_d;
    if (ld) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sparse_triple_transpose.sv */
`timescale 1ns / 1ps
`default_nettype none

// Dense-to-sparse converter: takes a row_count x column_count matrix one element per beat
// in row-major order (one beat per cycle) and stores up to MAX_NONZERO nonzero triples;
// further nonzeros are dropped and flagged in overflow. After the last element it emits a
// header and the triples in scan order (list_kind 0), then a header with rows and columns
// swapped and the triples sorted by column (list_kind 1); tlast marks the final beat. From
// the last element the input is held off until the transposed list has been read out of
// the store; the readout time is set by the single read port of the triple store, each
// read being issued in a read state and presented in the wait state that follows it.
// Size writes take effect at once and restart the matrix; write them only while idle.
module sparse_triple_transpose import stt_pkg::*; #(
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int MAX_NONZERO = DEF_MAX_NONZERO,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [ELEM_W-1:0]     s_axis_tdata,   // element_value
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // row_field[3:0], column_field[7:4], value_field[23:8], overflow[24], zero pad
  output logic      [TDATA_W-1:0]    m_axis_tdata,
  output logic      [TUSER_W-1:0]    m_axis_tuser,   // list_kind[0], is_header[1]
  output logic                       m_axis_tlast
);

  localparam int AddrW = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  trip_t            ram_wdata, ram_rdata;
  logic             job_push, job_full, job_valid, job_pop, job_done;
  job_t             job_in, job_out;
  res_t             res;

  stt_front #(
    .MAX_DIM     (MAX_DIM),
    .MAX_NONZERO (MAX_NONZERO),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (AddrW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full),
    .job_done_i  (job_done)
  );

  stt_ram #(
    .WIDTH  (TRIP_W),
    .DEPTH  (MAX_NONZERO),
    .ADDR_W (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stt_fifo u_jobq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (job_full),
    .valid_o     (job_valid),
    .pop_i       (job_pop),
    .pop_data_o  (job_out)
  );

  stt_back #(
    .MAX_NONZERO (MAX_NONZERO),
    .ADDR_W      (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .job_done_o  (job_done),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {{TDATA_PAD{1'b0}}, res.ovf, res.val, res.col, res.row};
  assign m_axis_tuser = {res.hdr, res.kind};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

/* hw/rtl/stt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module stt_checker import stt_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  cfg_we_i,
  input wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [ELEM_W-1:0]     s_axis_tdata,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [TDATA_W-1:0]    m_axis_tdata,
  input wire logic [TUSER_W-1:0]    m_axis_tuser,
  input wire logic                  m_axis_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // the run always ends inside the transposed list
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] == KIND_TRANSPOSE)
    else $error("tlast outside transposed list");

  // headers carry sizes of at least one
  a_hdr_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tdata[3:0] != 4'd0 && m_axis_tdata[7:4] != 4'd0)
    else $error("header with zero size");

  // empty transposed list: its header closes the run
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] && m_axis_tuser[0] == KIND_TRANSPOSE
    && m_axis_tdata[23:8] == 16'd0 |-> m_axis_tlast)
    else $error("empty transposed header without tlast");

endmodule

bind sparse_triple_transpose stt_checker u_chk (.*);

`default_nettype wire

/* sim/tb_sparse_triple_transpose.sv */
`timescale 1ns / 1ps

// Predicts the two lists of each matrix and checks output beats against them in order.
class triple_board;
  logic [stt_pkg::DIM_W-1:0] rows_reg;
  logic [stt_pkg::DIM_W-1:0] cols_reg;
  int                        elem_idx;
  int                        nz_n;
  bit                        dropped;
  stt_pkg::trip_t            nz_store[stt_pkg::DEF_MAX_NONZERO];
  stt_pkg::res_t             beats_due[$];
  int                        mismatches;

  function new();
    rows_reg   = 1;
    cols_reg   = 1;
    elem_idx   = 0;
    nz_n       = 0;
    dropped    = 0;
    mismatches = 0;
  endfunction

  // size as the block uses it: zero acts as one, clamp at the maximum
  function int span(logic [stt_pkg::DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > stt_pkg::DEF_MAX_DIM) return stt_pkg::DEF_MAX_DIM;
    return d;
  endfunction

  function void write_reg(logic [stt_pkg::CFG_IDX_W-1:0] idx,
                          logic [stt_pkg::CFG_DATA_W-1:0] d);
    if (idx == stt_pkg::REG_ROW_COUNT) begin
      rows_reg = d;
    end else begin
      cols_reg = d;
    end
    elem_idx = 0;
    nz_n     = 0;
    dropped  = 0;
  endfunction

  function void due(logic kind, logic hdr, int row, int col, logic [stt_pkg::ELEM_W-1:0] val);
    stt_pkg::res_t b;
    b.kind = kind;
    b.hdr  = hdr;
    b.row  = stt_pkg::DIM_W'(row);
    b.col  = stt_pkg::DIM_W'(col);
    b.val  = val;
    b.ovf  = dropped;
    b.last = 1'b0;
    beats_due.push_back(b);
  endfunction

  function void take_element(logic [stt_pkg::ELEM_W-1:0] v);
    int rows;
    int cols;
    rows = span(rows_reg);
    cols = span(cols_reg);
    if (v != 0) begin
      if (nz_n < stt_pkg::DEF_MAX_NONZERO) begin
        nz_store[nz_n].row = stt_pkg::DIM_W'(elem_idx / cols);
        nz_store[nz_n].col = stt_pkg::DIM_W'(elem_idx % cols);
        nz_store[nz_n].val = v;
        nz_n++;
      end else begin
        dropped = 1'b1;
      end
    end
    elem_idx++;
    if (elem_idx < rows * cols) return;

    due(stt_pkg::KIND_TRIPLE, 1'b1, rows, cols, stt_pkg::ELEM_W'(nz_n));
    for (int i = 0; i < nz_n; i++) begin
      due(stt_pkg::KIND_TRIPLE, 1'b0, nz_store[i].row, nz_store[i].col, nz_store[i].val);
    end
    due(stt_pkg::KIND_TRANSPOSE, 1'b1, cols, rows, stt_pkg::ELEM_W'(nz_n));
    for (int c = 0; c < cols; c++) begin
      for (int i = 0; i < nz_n; i++) begin
        if (nz_store[i].col == c) begin
          due(stt_pkg::KIND_TRANSPOSE, 1'b0, c, nz_store[i].row, nz_store[i].val);
        end
      end
    end
    beats_due[beats_due.size() - 1].last = 1'b1;
    elem_idx = 0;
    nz_n     = 0;
    dropped  = 0;
  endfunction

  function string show(stt_pkg::res_t b);
    return $sformatf("kind=%0d hdr=%0d row=%0d col=%0d val=%h ovf=%0d last=%0d",
                     b.kind, b.hdr, b.row, b.col, b.val, b.ovf, b.last);
  endfunction

  function void check_beat(stt_pkg::res_t got);
    stt_pkg::res_t want;
    if (beats_due.size() == 0) begin
      if (mismatches < 10) $display("unexpected beat: %s", show(got));
      mismatches++;
      return;
    end
    want = beats_due.pop_front();
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("mismatch: expected %s", show(want));
        $display("          actual   %s", show(got));
      end
      mismatches++;
    end
  endfunction

  function int outstanding();
    return beats_due.size();
  endfunction
endclass

module tb_sparse_triple_transpose;
  import stt_pkg::*;

  localparam int SETTLE_CYCLES    = 320;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int ITEM_TARGET      = 160;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [ELEM_W-1:0]     s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic [TUSER_W-1:0]    m_axis_tuser;
  logic                  m_axis_tlast;

  triple_board board = new();
  int elements_sent = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit rx_long_hold = 1'b0;

  sparse_triple_transpose uut (.*);

  always #10 clk_i = ~clk_i;

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
    if (r < 7) return $urandom_range(1, 4);
    return $urandom_range(5, 8);
  endfunction

  function automatic logic [ELEM_W-1:0] next_value(int density);
    logic [ELEM_W-1:0] v;
    if ($urandom_range(1, 100) > density) return '0;
    case ($urandom_range(0, 7))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = 16'hffff;
      3: v = 16'h0001;
      default: v = ELEM_W'($urandom);
    endcase
    if (v == 0) v = 16'h0001;
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after the accepting edge
  task automatic send_element(input logic [ELEM_W-1:0] v);
    int gap;
    gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= v;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_element(v);
    elements_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain(input int extra);
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    board.write_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_list(input logic [ELEM_W-1:0] seq[$]);
    foreach (seq[i]) send_element(seq[i]);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
      end else if (!rx_steady && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (idle_len()) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser[0];
      got.hdr  = m_axis_tuser[1];
      got.row  = m_axis_tdata[3:0];
      got.col  = m_axis_tdata[7:4];
      got.val  = m_axis_tdata[23:8];
      got.ovf  = m_axis_tdata[24];
      got.last = m_axis_tlast;
      board.check_beat(got);
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int rows_sel;
    int cols_sel;
    int density;
    int mats;
    int n_elem;
    int phase;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_ROW_COUNT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 1x1 out of reset: each element is a whole matrix
    send_list('{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001});
    drain(SETTLE_CYCLES);
    // zero rows acts as one, fifteen columns clamps to eight
    write_size(REG_ROW_COUNT, 4'd0);
    write_size(REG_COLUMN_COUNT, 4'd15);
    send_list('{16'h0000, 16'h8000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h7fff,
                16'h0000});
    drain(SETTLE_CYCLES);
    write_size(REG_ROW_COUNT, 4'd15);
    write_size(REG_COLUMN_COUNT, 4'd0);
    send_list('{16'hffff, 16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'h0000, 16'h0000,
                16'h8000});
    drain(SETTLE_CYCLES);

    phase = 0;
    while (elements_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        // full 8x8: store fills and overflow is flagged
        rows_sel = 8;
        cols_sel = 8;
        density  = 100;
        mats     = 1;
      end else if (phase == 1) begin
        rows_sel = 2;
        cols_sel = 3;
        density  = 85;
        mats     = 3;
      end else begin
        rows_sel = pick_dim();
        cols_sel = pick_dim();
        case ($urandom_range(0, 4))
          0: density = 0;
          1: density = 25;
          2: density = 50;
          3: density = 85;
          default: density = 100;
        endcase
        mats = $urandom_range(1, 3);
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      write_size(REG_ROW_COUNT, CFG_DATA_W'(rows_sel));
      write_size(REG_COLUMN_COUNT, CFG_DATA_W'(cols_sel));
      n_elem = board.span(DIM_W'(rows_sel)) * board.span(DIM_W'(cols_sel));
      // receiver holds off while several matrices are offered
      if (phase == 1) rx_long_hold = 1'b1;
      for (int m = 0; m < mats; m++) begin
        for (int e = 0; e < n_elem; e++) send_element(next_value(density));
        if ($urandom_range(0, 4) == 0) drain(0);
      end
      drain(SETTLE_CYCLES);
      phase++;
    end

    drain(SETTLE_CYCLES);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/stt_pkg.sv
hw/rtl/stt_ram.sv
hw/rtl/stt_fifo.sv
hw/rtl/stt_front.sv
hw/rtl/stt_back.sv
hw/rtl/sparse_triple_transpose.sv
hw/rtl/stt_checker.sv
sim/tb_sparse_triple_transpose.sv
